>>> sv/fps_pkg.sv
// Package with the shared constants and point type of the funnel path smoother.
`timescale 1ns / 1ps
package fps_pkg;
	localparam int COORD_BITS  = 16;
	localparam int CHAIN_DEPTH = 32;
	localparam int CNT_W       = $clog2(CHAIN_DEPTH + 1);
	localparam int ADDR_W      = $clog2(CHAIN_DEPTH);
	localparam int PT_W        = 2 * COORD_BITS;
	localparam int DIFF_W      = COORD_BITS + 1;
	localparam int PROD_W      = 2 * DIFF_W;

	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_PORTAL = 2'd1;
	localparam logic [1:0] CMD_GOAL   = 2'd2;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} point_t;
endpackage

>>> sv/fps_ram.sv
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps
module fps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> sv/funnel_path_smoother.sv
// Top level of the funnel path smoother: sequencer, chain memories and shared cross unit.
// The block turns a portal corridor into a pulled string of waypoints. A path is a start
// transaction, one portal transaction per portal and a goal transaction; waypoints leave
// on the result channel, the goal (or a chain overflow error) carrying final_point. One
// shared cross-product unit, one multiplier and a compare per test, does all geometry, and
// each chain lives in a small memory with a registered read. The block takes one input
// transaction at a time: a start loads both chains; a portal runs a test for each side,
// one for each vertex popped and, when a side moves the apex, one for each vertex walked
// past; a goal tests both tips and, when it lies outside the funnel, walks vertices as
// for a portal. Each waypoint may wait for the result register to drain.
`timescale 1ns / 1ps
module funnel_path_smoother
	import fps_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [1:0]                   command,
	input  logic signed [COORD_BITS-1:0] left_x,
	input  logic signed [COORD_BITS-1:0] left_y,
	input  logic signed [COORD_BITS-1:0] right_x,
	input  logic signed [COORD_BITS-1:0] right_y,
	output logic                         waypoint_valid,
	input  logic                         waypoint_ready,
	output logic signed [COORD_BITS-1:0] waypoint_x,
	output logic signed [COORD_BITS-1:0] waypoint_y,
	output logic                         final_point,
	output logic                         status
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_SIDE_BEGIN, ST_MUL1, ST_MUL2, ST_T1, ST_POP_RD, ST_POP_WAIT,
		ST_POP_CHK, ST_PUSH, ST_SIDE_DONE, ST_WALK_RD, ST_WALK_WAIT, ST_WALK_CHK,
		ST_WALK_POP, ST_NEWAPEX0, ST_NEWAPEX1, ST_G_L, ST_G_R, ST_GOAL_EMIT,
		ST_ERR, ST_EMIT
	} state_t;

	state_t state_q, ret_q, eret_q;
	logic   goal_q, side_q, ch_q, active_q, sl_neg_q;
	point_t cur_q, b_q, u_q, apex_q, ltip_q, rtip_q, last_q, e_pt_q;
	logic   e_fin_q, e_st_q, e_dedup_q, e_setlast_q;
	logic [CNT_W-1:0] lcnt_q, rcnt_q;
	logic signed [PROD_W-1:0] pa_q, pb_q;

	logic   out_valid_q, fin_q, st_q;
	point_t out_pt_q;

	// Chain memories.
	logic              l_we, r_we;
	logic [ADDR_W-1:0] l_waddr, r_waddr, l_raddr, r_raddr;
	point_t            l_wdata, r_wdata, l_rdata, r_rdata;

	fps_ram #(.WIDTH(PT_W), .DEPTH(CHAIN_DEPTH)) u_left_ram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);
	fps_ram #(.WIDTH(PT_W), .DEPTH(CHAIN_DEPTH)) u_right_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	// Selected chain view.
	logic [CNT_W-1:0] cnt_sel;
	point_t           tip_sel, rd_sel;
	logic             accept;
	point_t           in_a;
	assign cnt_sel = ch_q ? rcnt_q : lcnt_q;
	assign tip_sel = ch_q ? rtip_q : ltip_q;
	assign rd_sel  = ch_q ? r_rdata : l_rdata;
	assign accept  = item_valid && item_ready;
	assign in_a    = '{x: left_x, y: left_y};
	assign l_raddr = ADDR_W'(lcnt_q - CNT_W'(2));
	assign r_raddr = ADDR_W'(rcnt_q - CNT_W'(2));

	// Shared cross unit: differences against the apex, sign of the result.
	logic signed [DIFF_W-1:0] dux, duy, dcx, dcy;
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     cr_pos, cr_neg, ok;
	assign dux    = $signed({u_q.x[COORD_BITS-1], u_q.x}) -
			$signed({apex_q.x[COORD_BITS-1], apex_q.x});
	assign duy    = $signed({u_q.y[COORD_BITS-1], u_q.y}) -
			$signed({apex_q.y[COORD_BITS-1], apex_q.y});
	assign dcx    = $signed({cur_q.x[COORD_BITS-1], cur_q.x}) -
			$signed({apex_q.x[COORD_BITS-1], apex_q.x});
	assign dcy    = $signed({cur_q.y[COORD_BITS-1], cur_q.y}) -
			$signed({apex_q.y[COORD_BITS-1], apex_q.y});
	// One multiplier serves both products of a test, one per cycle.
	assign mul_a  = (state_q == ST_MUL1) ? dux : duy;
	assign mul_b  = (state_q == ST_MUL1) ? dcy : dcx;
	assign prod   = mul_a * mul_b;
	assign cr_pos = pa_q > pb_q;
	assign cr_neg = pa_q < pb_q;
	// Inside test: the left chain keeps non-negative, the right non-positive.
	assign ok     = ch_q ? !cr_pos : !cr_neg;

	// The result register takes a new waypoint when it is free or draining.
	logic emit_load;
	assign emit_load = (state_q == ST_EMIT) && !(e_dedup_q && e_pt_q == last_q) &&
			(!out_valid_q || waypoint_ready);

	// Memory writes issued by the sequencer.
	always_comb begin
		l_we    = 1'b0;
		r_we    = 1'b0;
		l_waddr = '0;
		r_waddr = '0;
		l_wdata = cur_q;
		r_wdata = cur_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_START) begin
					l_we    = 1'b1;
					r_we    = 1'b1;
					l_wdata = in_a;
					r_wdata = in_a;
				end
			end
			ST_PUSH: begin
				if (cnt_sel < CNT_W'(CHAIN_DEPTH)) begin
					l_we    = !ch_q;
					r_we    = ch_q;
					l_waddr = ADDR_W'(cnt_sel);
					r_waddr = ADDR_W'(cnt_sel);
				end
			end
			ST_NEWAPEX0: begin
				l_we    = 1'b1;
				r_we    = 1'b1;
				l_wdata = tip_sel;
				r_wdata = tip_sel;
			end
			ST_NEWAPEX1: begin
				l_we    = !side_q;
				r_we    = side_q;
				l_waddr = ADDR_W'(1);
				r_waddr = ADDR_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Sequencer with the chain state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			eret_q      <= ST_IDLE;
			active_q    <= 1'b0;
			lcnt_q      <= '0;
			rcnt_q      <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (waypoint_ready && !emit_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_q  <= in_a;
						b_q    <= '{x: right_x, y: right_y};
						goal_q <= command == CMD_GOAL;
						side_q <= 1'b0;
						if (command == CMD_START) begin
							apex_q      <= in_a;
							ltip_q      <= in_a;
							rtip_q      <= in_a;
							lcnt_q      <= CNT_W'(1);
							rcnt_q      <= CNT_W'(1);
							active_q    <= 1'b1;
							e_pt_q      <= in_a;
							e_fin_q     <= 1'b0;
							e_st_q      <= 1'b0;
							e_dedup_q   <= 1'b0;
							e_setlast_q <= 1'b1;
							eret_q      <= ST_IDLE;
							state_q     <= ST_EMIT;
						end else if (active_q && command == CMD_PORTAL) begin
							state_q <= ST_SIDE_BEGIN;
						end else if (active_q && command == CMD_GOAL) begin
							u_q     <= ltip_q;
							ret_q   <= ST_G_L;
							state_q <= ST_MUL1;
						end
					end
				end
				ST_SIDE_BEGIN: begin
					u_q     <= side_q ? rtip_q : ltip_q;
					ret_q   <= ST_T1;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					pa_q    <= prod;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					pb_q    <= prod;
					state_q <= ret_q;
				end
				ST_T1: begin
					// Inside the funnel tightens this side, else the apex moves.
					if (side_q ? !cr_pos : !cr_neg) begin
						ch_q    <= side_q;
						state_q <= ST_POP_RD;
					end else begin
						ch_q    <= !side_q;
						state_q <= ST_WALK_RD;
					end
				end
				ST_POP_RD: begin
					state_q <= (cnt_sel > CNT_W'(1)) ? ST_POP_WAIT : ST_PUSH;
				end
				ST_POP_WAIT: begin
					u_q     <= rd_sel;
					ret_q   <= ST_POP_CHK;
					state_q <= ST_MUL1;
				end
				ST_POP_CHK: begin
					if (ok) begin
						if (ch_q) begin
							rcnt_q <= rcnt_q - CNT_W'(1);
							rtip_q <= u_q;
						end else begin
							lcnt_q <= lcnt_q - CNT_W'(1);
							ltip_q <= u_q;
						end
						state_q <= ST_POP_RD;
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (cnt_sel >= CNT_W'(CHAIN_DEPTH)) begin
						state_q <= ST_ERR;
					end else begin
						if (ch_q) begin
							rcnt_q <= rcnt_q + CNT_W'(1);
							rtip_q <= cur_q;
						end else begin
							lcnt_q <= lcnt_q + CNT_W'(1);
							ltip_q <= cur_q;
						end
						state_q <= ST_SIDE_DONE;
					end
				end
				ST_SIDE_DONE: begin
					if (!side_q) begin
						side_q  <= 1'b1;
						cur_q   <= b_q;
						state_q <= ST_SIDE_BEGIN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK_RD: begin
					if (cnt_sel > CNT_W'(1)) begin
						state_q <= ST_WALK_WAIT;
					end else begin
						state_q <= goal_q ? ST_GOAL_EMIT : ST_NEWAPEX0;
					end
				end
				ST_WALK_WAIT: begin
					u_q     <= rd_sel;
					ret_q   <= ST_WALK_CHK;
					state_q <= ST_MUL1;
				end
				ST_WALK_CHK: begin
					// Each vertex walked past becomes a waypoint.
					if (ok) begin
						e_pt_q      <= tip_sel;
						e_fin_q     <= 1'b0;
						e_st_q      <= 1'b0;
						e_dedup_q   <= 1'b1;
						e_setlast_q <= 1'b1;
						eret_q      <= ST_WALK_POP;
						state_q     <= ST_EMIT;
					end else begin
						state_q <= goal_q ? ST_GOAL_EMIT : ST_NEWAPEX0;
					end
				end
				ST_WALK_POP: begin
					if (ch_q) begin
						rcnt_q <= rcnt_q - CNT_W'(1);
						rtip_q <= u_q;
					end else begin
						lcnt_q <= lcnt_q - CNT_W'(1);
						ltip_q <= u_q;
					end
					state_q <= ST_WALK_RD;
				end
				ST_NEWAPEX0: begin
					// The walked chain's tip is the new apex of both chains.
					apex_q <= tip_sel;
					if (ch_q) begin
						rcnt_q <= CNT_W'(1);
						lcnt_q <= CNT_W'(2);
						ltip_q <= cur_q;
					end else begin
						lcnt_q <= CNT_W'(1);
						rcnt_q <= CNT_W'(2);
						rtip_q <= cur_q;
					end
					state_q <= ST_NEWAPEX1;
				end
				ST_NEWAPEX1: begin
					state_q <= ST_SIDE_DONE;
				end
				ST_G_L: begin
					sl_neg_q <= cr_neg;
					u_q      <= rtip_q;
					ret_q    <= ST_G_R;
					state_q  <= ST_MUL1;
				end
				ST_G_R: begin
					if (!sl_neg_q && !cr_pos) begin
						state_q <= ST_GOAL_EMIT;
					end else begin
						ch_q    <= sl_neg_q;
						state_q <= ST_WALK_RD;
					end
				end
				ST_GOAL_EMIT: begin
					active_q    <= 1'b0;
					e_pt_q      <= cur_q;
					e_fin_q     <= 1'b1;
					e_st_q      <= 1'b0;
					e_dedup_q   <= 1'b0;
					e_setlast_q <= 1'b1;
					eret_q      <= ST_IDLE;
					state_q     <= ST_EMIT;
				end
				ST_ERR: begin
					active_q    <= 1'b0;
					e_pt_q      <= '0;
					e_fin_q     <= 1'b1;
					e_st_q      <= 1'b1;
					e_dedup_q   <= 1'b0;
					e_setlast_q <= 1'b0;
					eret_q      <= ST_IDLE;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					// Suppress repeats, otherwise wait for the result register.
					if (e_dedup_q && e_pt_q == last_q) begin
						state_q <= eret_q;
					end else if (emit_load) begin
						out_valid_q <= 1'b1;
						out_pt_q    <= e_pt_q;
						fin_q       <= e_fin_q;
						st_q        <= e_st_q;
						if (e_setlast_q) begin
							last_q <= e_pt_q;
						end
						state_q <= eret_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_ready     = state_q == ST_IDLE;
	assign waypoint_valid = out_valid_q;
	assign waypoint_x     = $signed(out_pt_q.x);
	assign waypoint_y     = $signed(out_pt_q.y);
	assign final_point    = fin_q;
	assign status         = st_q;
endmodule
